/* src/first_fit_heap_allocator_core_defines.svh */
// Assertion macros used by the checker file of the heap allocator core.
// Depends on nothing; included by bare file name.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define FFHA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ffha_pkg.sv */
// Package of the first-fit heap allocator: widths, codes, payload types and
// the sequencer state type. Depends on nothing.
package ffha_pkg;

    localparam int MAX_CHUNKS = 16;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int ADDR_W     = 30;
    localparam int HEAP_W     = 31;
    localparam int HDR_W      = 8;
    localparam int CFG_IDX_W  = 8;

    localparam logic [HEAP_W-1:0] HEAP_LIMIT     = HEAP_W'(32'h3FFF_FFFF);
    localparam logic [HEAP_W-1:0] HEAP_RESET     = HEAP_W'(32'h4000_0000);
    localparam logic [HDR_W-1:0]  HEADER_RESET   = HDR_W'(32);

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = CFG_IDX_W'(1);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_BLOCK  = 2'd3
    } t_status;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        t_status           status;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] size;
        logic              busy;
    } t_chunk;

    typedef struct packed {
        logic             en_off;
        logic             en_size;
        logic             en_busy;
        logic [IDX_W-1:0] idx;
        t_chunk           data;
    } t_tbl_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_KEY,
        S_SCAN,
        S_FSCAN,
        S_CHKREM,
        S_SHIFT,
        S_DOFF,
        S_NEWOFF,
        S_NEWSIZE,
        S_FINISH
    } t_state;

endpackage

/* src/ffha_alu.sv */
// Shared add/subtract unit of the heap allocator sequencer.
// Depends on ffha_pkg.
module ffha_alu (
    input  logic [ffha_pkg::HEAP_W-1:0] i_a,
    input  logic [ffha_pkg::HEAP_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [ffha_pkg::HEAP_W-1:0] o_result,
    output logic                        o_borrow
);
    import ffha_pkg::*;

    logic [HEAP_W:0] w_sum;

    // Subtraction is a plus the inverted b plus one; the carry out is the
    // inverse of the borrow.
    assign w_sum    = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)}
                    + {{HEAP_W{1'b0}}, i_sub};
    assign o_result = w_sum[HEAP_W-1:0];
    assign o_borrow = i_sub & ~w_sum[HEAP_W];

endmodule

/* src/ffha_table.sv */
// Chunk table of the heap allocator: offset, size and busy mark per entry,
// one write port and one read port. Depends on ffha_pkg.
module ffha_table (
    input  logic                       i_clk,
    input  ffha_pkg::t_tbl_wr          i_wr,
    input  logic [ffha_pkg::IDX_W-1:0] i_rd_idx,
    output ffha_pkg::t_chunk           o_rd
);
    import ffha_pkg::*;

    logic [ADDR_W-1:0] r_off  [MAX_CHUNKS];
    logic [ADDR_W-1:0] r_size [MAX_CHUNKS];
    logic              r_busy [MAX_CHUNKS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en_off) begin
            r_off[i_wr.idx] <= i_wr.data.off;
        end
        if (i_wr.en_size) begin
            r_size[i_wr.idx] <= i_wr.data.size;
        end
        if (i_wr.en_busy) begin
            r_busy[i_wr.idx] <= i_wr.data.busy;
        end
    end

    assign o_rd.off  = r_off[i_rd_idx];
    assign o_rd.size = r_size[i_rd_idx];
    assign o_rd.busy = r_busy[i_rd_idx];

endmodule

/* src/first_fit_heap_allocator_core.sv */
// Top level of the first-fit heap allocator: sequencer, configuration
// registers and result register. Depends on ffha_pkg, ffha_alu, ffha_table.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One beat is worked on at a time by a sequencer around a single add/subtract
// unit. An allocate walks the table entries (up to MAX_CHUNKS) for the first
// free chunk that fits; a split also moves later entries up to open a slot,
// while a whole-chunk grant or a table-full result moves none. A miss walks
// every entry plus one end check. The first allocate after reset also sets
// the heap up. A free walks the table for a matching block, and ends at once
// before the heap is set up.
// Reset is synchronous and active low; it empties the table logically and
// restores the register defaults. The table contents themselves are not reset.
// The result register lets the next beat be accepted while a result waits;
// the sequencer only stalls at its last step if that register is still full.
module first_fit_heap_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ffha_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ffha_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffha_pkg::HEAP_W-1:0]    i_cfg_data
);
    import ffha_pkg::*;

    // Sequencer state and the item under work.
    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    t_status           r_status;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_count;
    logic              r_started;
    logic              r_split;
    logic [ADDR_W-1:0] r_rem;
    logic [ADDR_W-1:0] r_key;
    logic [ADDR_W-1:0] r_res_addr;

    // Configuration registers.
    logic [HEAP_W-1:0] r_heap_bytes;
    logic [HDR_W-1:0]  r_header_bytes;

    // Result register.
    logic              r_out_valid;
    t_out_item         r_out;

    // Datapath wires.
    logic [HEAP_W-1:0] w_a;
    logic [HEAP_W-1:0] w_b;
    logic              w_sub;
    logic [HEAP_W-1:0] w_res;
    logic              w_borrow;
    logic [HEAP_W-1:0] w_heap_c;
    logic [HEAP_W-1:0] w_hdr_ext;
    logic [IDX_W-1:0]  w_rd_idx;
    t_chunk            w_rd;
    t_tbl_wr           w_wr;
    logic              w_accept;
    logic              w_at_end;
    logic              w_fit;
    logic              w_match;
    logic              w_full;
    logic              w_shift_done;
    logic              w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_heap_c     = (r_heap_bytes > HEAP_LIMIT) ? HEAP_LIMIT : r_heap_bytes;
    assign w_hdr_ext    = {{(HEAP_W-HDR_W){1'b0}}, r_header_bytes};
    assign w_at_end     = (r_idx == r_count);
    assign w_fit        = !w_rd.busy && !w_borrow;
    assign w_match      = (w_rd.off == r_key);
    assign w_full       = (r_count == CNT_W'(MAX_CHUNKS));
    assign w_shift_done = (r_k == r_idx + CNT_W'(1));
    assign w_out_free   = !r_out_valid || i_out_ready;

    // While entries are moved up, the table is read one below the slot written.
    assign w_rd_idx = (r_state == S_SHIFT) ? IDX_W'(r_k - CNT_W'(1)) : r_idx[IDX_W-1:0];

    ffha_alu u_alu (
        .i_a      (w_a),
        .i_b      (w_b),
        .i_sub    (w_sub),
        .o_result (w_res),
        .o_borrow (w_borrow)
    );

    ffha_table u_table (
        .i_clk    (i_clk),
        .i_wr     (w_wr),
        .i_rd_idx (w_rd_idx),
        .o_rd     (w_rd)
    );

    // Operand selection for the shared unit. Data offsets are compared by
    // turning the freed address back into a header offset once, so the walk
    // over the table needs only an equality test.
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        unique case (r_state)
            S_INIT: begin
                w_a   = w_heap_c;
                w_b   = w_hdr_ext;
                w_sub = 1'b1;
            end
            S_KEY: begin
                w_a   = {1'b0, r_item.block_address};
                w_b   = w_hdr_ext;
                w_sub = 1'b1;
            end
            S_SCAN: begin
                w_a   = {1'b0, w_rd.size};
                w_b   = {1'b0, r_item.request_size};
                w_sub = 1'b1;
            end
            S_CHKREM: begin
                w_a   = w_hdr_ext;
                w_b   = {1'b0, r_rem};
                w_sub = 1'b1;
            end
            S_DOFF: begin
                w_a = {1'b0, w_rd.off};
                w_b = w_hdr_ext;
            end
            S_NEWOFF: begin
                w_a = {1'b0, r_res_addr};
                w_b = {1'b0, r_item.request_size};
            end
            S_NEWSIZE: begin
                w_a   = {1'b0, r_rem};
                w_b   = w_hdr_ext;
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.action == ACT_ALLOC) begin
                        n_state = r_started ? S_SCAN : S_INIT;
                    end else begin
                        n_state = r_started ? S_KEY : S_FINISH;
                    end
                end
            end
            S_INIT:  n_state = S_SCAN;
            S_KEY:   n_state = S_FSCAN;
            S_SCAN: begin
                if (w_at_end) begin
                    n_state = S_FINISH;
                end else if (w_fit) begin
                    n_state = S_CHKREM;
                end
            end
            S_FSCAN: begin
                if (w_at_end || w_match) begin
                    n_state = S_FINISH;
                end
            end
            S_CHKREM: begin
                if (!w_borrow) begin
                    n_state = S_DOFF;
                end else if (w_full) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_shift_done) begin
                    n_state = S_DOFF;
                end
            end
            S_DOFF:    n_state = r_split ? S_NEWOFF : S_FINISH;
            S_NEWOFF:  n_state = S_NEWSIZE;
            S_NEWSIZE: n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Table writes for each step of the sequencer.
    always_comb begin
        w_wr      = '0;
        w_wr.idx  = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_INIT: begin
                // One free chunk spanning the heap; a heap no larger than a
                // header leaves it empty.
                w_wr.en_off    = 1'b1;
                w_wr.en_size   = 1'b1;
                w_wr.en_busy   = 1'b1;
                w_wr.data.size = (w_borrow || (w_res == '0)) ? '0 : w_res[ADDR_W-1:0];
            end
            S_FSCAN: begin
                if (!w_at_end && w_match) begin
                    w_wr.en_busy = 1'b1;
                end
            end
            S_CHKREM: begin
                if (!w_borrow) begin
                    w_wr.en_busy   = 1'b1;
                    w_wr.data.busy = 1'b1;
                end else if (!w_full) begin
                    w_wr.en_size   = 1'b1;
                    w_wr.en_busy   = 1'b1;
                    w_wr.data.size = r_item.request_size;
                    w_wr.data.busy = 1'b1;
                end
            end
            S_SHIFT: begin
                if (!w_shift_done) begin
                    w_wr.en_off  = 1'b1;
                    w_wr.en_size = 1'b1;
                    w_wr.en_busy = 1'b1;
                    w_wr.idx     = r_k[IDX_W-1:0];
                    w_wr.data    = w_rd;
                end
            end
            S_NEWOFF: begin
                w_wr.en_off   = 1'b1;
                w_wr.en_busy  = 1'b1;
                w_wr.idx      = IDX_W'(r_idx + CNT_W'(1));
                w_wr.data.off = w_res[ADDR_W-1:0];
            end
            S_NEWSIZE: begin
                w_wr.en_size   = 1'b1;
                w_wr.idx       = IDX_W'(r_idx + CNT_W'(1));
                w_wr.data.size = w_res[ADDR_W-1:0];
            end
            default: begin
                w_wr.en_off = 1'b0;
            end
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_started      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_heap_bytes   <= HEAP_RESET;
            r_header_bytes <= HEADER_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_HEAP_BYTES) begin
                    r_heap_bytes <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEADER_BYTES) begin
                    r_header_bytes <= i_cfg_data[HDR_W-1:0];
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item     <= i_in_data;
                        r_idx      <= '0;
                        r_res_addr <= '0;
                        r_status   <= (i_in_data.action == ACT_ALLOC) ? ST_NO_FIT
                                                                      : ST_NOT_BLOCK;
                    end
                end
                S_INIT: begin
                    r_count   <= CNT_W'(1);
                    r_started <= 1'b1;
                end
                S_KEY: begin
                    r_key <= w_res[ADDR_W-1:0];
                end
                S_SCAN: begin
                    if (!w_at_end) begin
                        if (w_fit) begin
                            r_rem <= w_res[ADDR_W-1:0];
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end
                end
                S_FSCAN: begin
                    if (!w_at_end) begin
                        if (w_match) begin
                            r_status <= ST_OK;
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end
                end
                S_CHKREM: begin
                    r_split  <= w_borrow;
                    r_k      <= r_count;
                    r_status <= (w_borrow && w_full) ? ST_TABLE_FULL : ST_OK;
                end
                S_SHIFT: begin
                    if (!w_shift_done) begin
                        r_k <= r_k - CNT_W'(1);
                    end
                end
                S_DOFF: begin
                    r_res_addr <= w_res[ADDR_W-1:0];
                end
                S_NEWSIZE: begin
                    r_count <= r_count + CNT_W'(1);
                end
                default: begin
                    r_k <= r_k;
                end
            endcase

            if ((r_state == S_FINISH) && w_out_free) begin
                r_out_valid    <= 1'b1;
                r_out.address  <= r_res_addr;
                r_out.status   <= r_status;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* src/ffha_checker.sv */
// Port-level assertions for the heap allocator core and the bind that
// attaches them. Depends on ffha_pkg and the shared assertion macros.
`include "first_fit_heap_allocator_core_defines.svh"

module ffha_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ffha_pkg::t_out_item o_out_data
);
    import ffha_pkg::*;

    // Reset leaves no result pending.
    `FFHA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    // The sequencer is busy right after it takes a beat.
    `FFHA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready right after accept")

    // Only a successful grant carries a nonzero address.
    `FFHA_ASSERT(a_addr_zero_on_fail, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.address == '0), "address on failed request")

    // A stalled result holds.
    `FFHA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);

/* sim/ffha_heap_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the first-fit heap allocator core: keeps its own chunk table,
// predicts the result of every accepted request beat and checks each result beat.
// Depends on ffha_pkg.
module ffha_heap_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  ffha_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  ffha_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffha_pkg::HEAP_W-1:0]    i_cfg_data,
    output int                             o_owed,
    output int                             o_failures,
    output int                             o_checked,
    output int                             o_ok,
    output int                             o_no_fit,
    output int                             o_full,
    output int                             o_not_block
);
    import ffha_pkg::*;

    logic [HEAP_W-1:0] heap_cfg = HEAP_RESET;
    logic [HDR_W-1:0]  hdr_cfg  = HEADER_RESET;

    logic [ADDR_W-1:0] chunk_off  [MAX_CHUNKS];
    logic [ADDR_W-1:0] chunk_len  [MAX_CHUNKS];
    logic              chunk_used [MAX_CHUNKS];
    int                chunk_total = 0;
    logic              heap_live   = 1'b0;

    t_out_item owed_results[$];

    int failures    = 0;
    int checked     = 0;
    int n_ok        = 0;
    int n_no_fit    = 0;
    int n_full      = 0;
    int n_not_block = 0;

    // Applies one request to the mirrored table and returns the result it earns.
    function automatic t_out_item predict_heap_op(input t_in_item req);
        t_out_item         res;
        logic [HEAP_W-1:0] heap;
        logic [ADDR_W-1:0] spare;
        int                hit;
        int                i;
        res.address = '0;
        hit = -1;
        if (req.action == ACT_ALLOC) begin
            // The first allocate after reset lays the heap out as one free chunk.
            if (!heap_live) begin
                heap = (heap_cfg > HEAP_LIMIT) ? HEAP_LIMIT : heap_cfg;
                chunk_off[0]  = '0;
                chunk_len[0]  = (heap > HEAP_W'(hdr_cfg)) ? ADDR_W'(heap - HEAP_W'(hdr_cfg)) : '0;
                chunk_used[0] = 1'b0;
                chunk_total   = 1;
                heap_live     = 1'b1;
            end
            res.status = ST_NO_FIT;
            for (i = 0; i < chunk_total; i++) begin
                if (hit < 0 && !chunk_used[i] && chunk_len[i] >= req.request_size) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                spare = chunk_len[hit] - req.request_size;
                if (spare <= ADDR_W'(hdr_cfg)) begin
                    chunk_used[hit] = 1'b1;
                    res.status = ST_OK;
                end else if (chunk_total >= MAX_CHUNKS) begin
                    res.status = ST_TABLE_FULL;
                end else begin
                    for (i = chunk_total; i > hit + 1; i--) begin
                        chunk_off[i]  = chunk_off[i-1];
                        chunk_len[i]  = chunk_len[i-1];
                        chunk_used[i] = chunk_used[i-1];
                    end
                    chunk_off[hit+1]  = chunk_off[hit] + ADDR_W'(hdr_cfg) + req.request_size;
                    chunk_len[hit+1]  = spare - ADDR_W'(hdr_cfg);
                    chunk_used[hit+1] = 1'b0;
                    chunk_total++;
                    chunk_len[hit]  = req.request_size;
                    chunk_used[hit] = 1'b1;
                    res.status = ST_OK;
                end
                if (res.status == ST_OK) begin
                    res.address = chunk_off[hit] + ADDR_W'(hdr_cfg);
                end
            end
        end else begin
            res.status = ST_NOT_BLOCK;
            if (heap_live) begin
                for (i = 0; i < chunk_total; i++) begin
                    if (hit < 0 &&
                        ADDR_W'(chunk_off[i] + ADDR_W'(hdr_cfg)) == req.block_address) begin
                        chunk_used[i] = 1'b0;
                        res.status = ST_OK;
                        hit = i;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            heap_cfg    = HEAP_RESET;
            hdr_cfg     = HEADER_RESET;
            chunk_total = 0;
            heap_live   = 1'b0;
            owed_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    failures++;
                    $display("%0t: result beat with nothing outstanding: expected none, got address 0x%h status %0d",
                             $time, i_out_data.address, i_out_data.status);
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    case (want.status)
                        ST_OK:         n_ok++;
                        ST_NO_FIT:     n_no_fit++;
                        ST_TABLE_FULL: n_full++;
                        default:       n_not_block++;
                    endcase
                    if (i_out_data.address !== want.address ||
                        i_out_data.status !== want.status) begin
                        failures++;
                        $display("%0t: result mismatch: expected address 0x%h status %0d, got address 0x%h status %0d",
                                 $time, want.address, want.status,
                                 i_out_data.address, i_out_data.status);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEAP_BYTES:   heap_cfg = i_cfg_data;
                    CFG_HEADER_BYTES: hdr_cfg  = i_cfg_data[HDR_W-1:0];
                    default:          ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(predict_heap_op(i_in_data));
            end
        end
        o_owed      <= owed_results.size();
        o_failures  <= failures;
        o_checked   <= checked;
        o_ok        <= n_ok;
        o_no_fit    <= n_no_fit;
        o_full      <= n_full;
        o_not_block <= n_not_block;
    end

endmodule

/* sim/tb_first_fit_heap_allocator_core.sv */
`timescale 1ns / 100ps
// Testbench top for the first-fit heap allocator core: drives request and
// register beats, stalls the result side and gives the verdict.
// Depends on ffha_pkg, ffha_heap_checker and the core itself.
module tb_first_fit_heap_allocator_core;
    import ffha_pkg::*;

    // Register index that maps to nothing; a write there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [HEAP_W-1:0]    cfg_data  = '0;

    int owed_count;
    int mismatch_total;
    int checked_total;
    int ok_total;
    int no_fit_total;
    int full_total;
    int not_block_total;

    // Header size currently programmed; the random requests size reuse
    // allocations around it so that whole-chunk grants keep happening.
    logic [HDR_W-1:0] hdr_now = HEADER_RESET;
    int               settings_made = 0;
    bit               src_calm  = 1'b0;
    bit               sink_calm = 1'b0;
    int               sink_hold = 0;

    // Stimulus bookkeeping: which request each result belongs to, the data
    // offsets handed out and still held, and the sizes of freed blocks.
    t_in_item          issued_items[$];
    logic [ADDR_W-1:0] live_addrs[$];
    logic [ADDR_W-1:0] live_sizes[$];
    logic [ADDR_W-1:0] reuse_sizes[$];

    logic      in_seen  = 1'b0;
    logic      out_seen = 1'b0;
    t_in_item  in_seen_item;
    t_out_item out_seen_item;

    first_fit_heap_allocator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ffha_heap_checker u_heap_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_owed      (owed_count),
        .o_failures  (mismatch_total),
        .o_checked   (checked_total),
        .o_ok        (ok_total),
        .o_no_fit    (no_fit_total),
        .o_full      (full_total),
        .o_not_block (not_block_total)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop, several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then
    // a long gap.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // The result side stalls at random, independent of valid. Calm stretches
    // keep ready high so the core also runs back to back.
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0) begin
            sink_calm = !sink_calm;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 2) == 0) begin
                sink_hold = idle_span();
            end
        end
    end

    // Handshakes are captured at the rising edge and the pools are updated at
    // the falling edge, so the stimulus process, which runs at the rising
    // edge, always reads settled pools.
    always @(posedge clk) begin
        in_seen       <= in_valid && in_ready;
        in_seen_item  <= in_data;
        out_seen      <= out_valid && out_ready;
        out_seen_item <= out_data;
    end

    always @(negedge clk) begin
        t_in_item sent;
        if (out_seen && issued_items.size() > 0) begin
            sent = issued_items.pop_front();
            if (sent.action == ACT_ALLOC && out_seen_item.status == ST_OK) begin
                live_addrs.push_back(out_seen_item.address);
                live_sizes.push_back(sent.request_size);
                if (live_addrs.size() > 48) begin
                    void'(live_addrs.pop_front());
                    void'(live_sizes.pop_front());
                end
            end
        end
        if (in_seen) begin
            issued_items.push_back(in_seen_item);
        end
    end

    // Presents one request beat and holds it until accepted, then idles for a
    // random number of cycles. With no idle the valid stays high into the
    // next beat.
    task automatic send_item(input t_in_item it);
        int gap;
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
        end
        gap = src_calm ? 0 : idle_span();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_alloc(input logic [ADDR_W-1:0] bytes);
        t_in_item it;
        it.action        = ACT_ALLOC;
        it.request_size  = bytes;
        it.block_address = ADDR_W'($urandom);
        send_item(it);
    endtask

    task automatic send_free(input logic [ADDR_W-1:0] addr);
        t_in_item it;
        it.action        = ACT_FREE;
        it.request_size  = ADDR_W'($urandom);
        it.block_address = addr;
        send_item(it);
    endtask

    // Stops sending and waits until every result owed has come back. Every
    // request earns exactly one result, so the core is idle after that; the
    // extra wait only covers the last result leaving the core.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HEAP_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEADER_BYTES) begin
            hdr_now = val[HDR_W-1:0];
        end
        settings_made++;
        @(posedge clk);
    endtask

    // Random request: mostly well-formed traffic (small allocations, frees of
    // blocks we hold, allocations sized to refill a freed block), plus full
    // range sizes, wild addresses and near-miss frees as noise. The field
    // that the action ignores is always random.
    function automatic t_in_item random_request();
        t_in_item          it;
        int                pick;
        int                j;
        logic [ADDR_W-1:0] sz;
        logic [ADDR_W-1:0] cut;
        it.action        = ACT_ALLOC;
        it.request_size  = ADDR_W'($urandom);
        it.block_address = ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            it.request_size = ADDR_W'($urandom_range(0, 512));
        end else if (pick < 57) begin
            if (reuse_sizes.size() > 0) begin
                j   = $urandom_range(0, reuse_sizes.size() - 1);
                sz  = reuse_sizes[j];
                cut = ADDR_W'($urandom_range(0, hdr_now));
                reuse_sizes.delete(j);
                it.request_size = (sz > cut) ? sz - cut : '0;
            end else begin
                it.request_size = ADDR_W'($urandom_range(0, 512));
            end
        end else if (pick < 62) begin
            // Full-range size: usually no fit, sometimes the big tail chunk.
        end else if (pick < 90) begin
            it.action = ACT_FREE;
            if (live_addrs.size() > 0) begin
                j = $urandom_range(0, live_addrs.size() - 1);
                it.block_address = live_addrs[j];
                reuse_sizes.push_back(live_sizes[j]);
                if (reuse_sizes.size() > 32) begin
                    void'(reuse_sizes.pop_front());
                end
                live_addrs.delete(j);
                live_sizes.delete(j);
            end else begin
                it.block_address = ADDR_W'(hdr_now);
            end
        end else if (pick < 95) begin
            it.action = ACT_FREE;
        end else begin
            // One byte off a held block, which must not match anything.
            it.action = ACT_FREE;
            if (live_addrs.size() > 0) begin
                j = $urandom_range(0, live_addrs.size() - 1);
                it.block_address = live_addrs[j] + ADDR_W'(1);
            end else begin
                it.block_address = ADDR_W'(hdr_now) - ADDR_W'(1);
            end
        end
        return it;
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0] hdr;
        int                p;
        int                n;
        hdr = ADDR_W'(HEADER_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Nothing is set up yet, so a free names no block.
        send_free(hdr);
        drain_results();
        // Oversized heap: it must be clamped to the 30-bit limit at set-up.
        write_reg(CFG_HEAP_BYTES, HEAP_W'(31'h7FFF_FFFF));
        // First allocate sets the heap up; the largest size cannot fit.
        send_alloc('1);
        // Zero-byte request takes chunk 0; its data sits right after a header.
        send_alloc('0);
        // This one lands in the next chunk, two headers into the heap.
        send_alloc(ADDR_W'(100));
        send_free(ADDR_W'(hdr * 2));
        // Freeing a block that is already free still matches.
        send_free(ADDR_W'(hdr * 2));
        // Remainder equals the header size: the whole chunk is granted.
        send_alloc(ADDR_W'(100) - hdr);
        send_free(ADDR_W'(hdr * 2));
        // Remainder one byte above the header: split off a one-byte chunk.
        send_alloc(ADDR_W'(100) - hdr - ADDR_W'(1));
        send_free('1);
        send_free(ADDR_W'(hdr * 2) - ADDR_W'(1));
        // Exact fit into the one-byte chunk.
        send_alloc(ADDR_W'(1));
        // Twelve more splits fill the table; the next split has no slot.
        for (n = 0; n < 12; n++) begin
            send_alloc(ADDR_W'(1 + 37 * n));
        end
        send_alloc(ADDR_W'(200));

        // Random part, in four register settings. The table set up above is
        // kept throughout; only the header size changes how it behaves.
        for (p = 0; p < 4; p++) begin
            drain_results();
            case (p)
                0: begin
                    write_reg(CFG_HEADER_BYTES, HEAP_W'(8'hFF));
                    write_reg(CFG_HEAP_BYTES, '0);
                end
                1: begin
                    write_reg(CFG_HEADER_BYTES, '0);
                    write_reg(CFG_HEAP_BYTES, HEAP_W'($urandom));
                end
                2: begin
                    // Junk in the upper data bits must be dropped.
                    write_reg(CFG_HEADER_BYTES, {(HEAP_W-HDR_W)'($urandom),
                                                 HDR_W'($urandom_range(1, 254))});
                    write_reg(CFG_UNMAPPED, HEAP_W'($urandom));
                end
                default: begin
                    write_reg(CFG_HEADER_BYTES, HEAP_W'(HEADER_RESET));
                    write_reg(CFG_HEAP_BYTES, HEAP_RESET);
                end
            endcase
            for (n = 0; n < 180; n++) begin
                // Mid-phase, let the core run completely dry once.
                if (p == 1 && n == 90) begin
                    drain_results();
                end
                send_item(random_request());
            end
        end

        drain_results();
        // Window for any stray result beat after the last one owed.
        repeat (40) @(posedge clk);

        $display("Checked %0d result beats over %0d register writes.", checked_total,
                 settings_made);
        $display("Results: %0d ok, %0d no fit, %0d table full, %0d not a block.",
                 ok_total, no_fit_total, full_total, not_block_total);
        if (mismatch_total == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/ffha_pkg.sv
src/ffha_alu.sv
src/ffha_table.sv
src/first_fit_heap_allocator_core.sv
src/ffha_checker.sv
sim/ffha_heap_checker.sv
sim/tb_first_fit_heap_allocator_core.sv
